@@ hw/rtl/vmnn_pkg.sv @@
// ----------------------------------------------------------------------------
// vmnn_pkg
// Shared sizes, codes and item types of the voxel map nearest neighbour block.
// ----------------------------------------------------------------------------
package vmnn_pkg;

	localparam int MAP_CAPACITY  = 4096;
	localparam int MAX_POINTS    = 16;
	localparam int KEY_BITS      = 20;
	localparam int NEIGHBOR_SPAN = 27;

	localparam int ENT_AW   = $clog2(MAP_CAPACITY);
	localparam int PT_IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PT_DEPTH = MAP_CAPACITY * (2 ** PT_IW);
	localparam int PT_AW    = ENT_AW + PT_IW;
	localparam int CNT_W    = $clog2(MAX_POINTS + 1);
	localparam int SCAN_W   = $clog2(MAP_CAPACITY + 1);
	localparam int NB_W     = $clog2(NEIGHBOR_SPAN);

	localparam int COORD_W   = 32;
	localparam int SUM_W     = 66;
	localparam int MD2_W     = 62;
	localparam int VS_W      = 31;
	localparam int PPV_W     = 5;
	localparam int RCNT_W    = 13;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam int DIV_STEPS  = 32;
	localparam int DIV_CW     = $clog2(DIV_STEPS);
	localparam int FIFO_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_PER  = 2'd2;

	typedef enum logic [1:0] {
		REQ_ADD,
		REQ_PRUNE,
		REQ_QUERY,
		REQ_NONE
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_FULL,
		ST_NONE
	} status_t;

	// index 0 is x, 1 is y, 2 is z
	typedef logic [2:0][COORD_W-1:0]  point_t;
	typedef logic [2:0][KEY_BITS-1:0] key_t;

	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] count;
		key_t             key;
	} entry_t;

	typedef struct packed {
		req_t   req;
		point_t pt;
		key_t   key;
	} cmd_t;

	typedef struct packed {
		logic              vld;
		logic [ENT_AW-1:0] ent;
		point_t            pt;
	} dist_in_t;

	typedef struct packed {
		logic              vld;
		logic [ENT_AW-1:0] ent;
		point_t            pt;
		logic [SUM_W-1:0]  sum;
	} dist_out_t;

	typedef struct packed {
		status_t           status;
		point_t            near;
		logic [RCNT_W-1:0] removed;
	} res_t;

endpackage

@@ hw/rtl/vmnn_ram.sv @@
// ----------------------------------------------------------------------------
// vmnn_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vmnn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/vmnn_fifo.sv @@
// ----------------------------------------------------------------------------
// vmnn_fifo
// Short command queue between the key front end and the table back end.
// ----------------------------------------------------------------------------
module vmnn_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vmnn_pkg::cmd_t din,
	input  logic           pop,
	output vmnn_pkg::cmd_t dout,
	output logic           full,
	output logic           empty
);
	import vmnn_pkg::*;

	localparam int FQ_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FQ_CW = $clog2(FIFO_DEPTH + 1);

	cmd_t             mem_q [FIFO_DEPTH];
	logic [FQ_AW-1:0] wr_q;
	logic [FQ_AW-1:0] rd_q;
	logic [FQ_CW-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == FQ_CW'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == FQ_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == FQ_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

@@ hw/rtl/vmnn_front.sv @@
// ----------------------------------------------------------------------------
// vmnn_front
// Takes items, works out the voxel key of each axis with three restoring
// dividers (one quotient bit per cycle) and queues the item for the back end.
// ----------------------------------------------------------------------------
module vmnn_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                req_type,
	input  logic signed [31:0]        x,
	input  logic signed [31:0]        y,
	input  logic signed [31:0]        z,
	input  logic [vmnn_pkg::VS_W-1:0] grid_step,
	input  logic                      hold,
	input  logic                      fifo_full,
	output logic                      push,
	output vmnn_pkg::cmd_t            cmd
);
	import vmnn_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} fstate_t;

	fstate_t           state_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [2:0][31:0]  quo_q;
	logic [2:0][31:0]  rem_q;
	logic [2:0]        neg_q;
	logic [VS_W-1:0]   div_q;
	req_t              req_q;
	point_t            pt_q;

	logic [2:0][31:0]  trial;
	logic [2:0][31:0]  quo_d;
	logic [2:0][31:0]  rem_d;
	key_t              key_d;
	point_t            in_pt;
	logic              accept;

	assign in_pt  = {z, y, x};
	assign busy   = (state_q != F_IDLE) || hold;
	assign accept = start && !busy;
	assign push   = (state_q == F_PUSH) && !fifo_full;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			trial[a] = {rem_q[a][30:0], quo_q[a][31]};
			if (trial[a] >= {1'b0, div_q}) begin
				rem_d[a] = trial[a] - {1'b0, div_q};
				quo_d[a] = {quo_q[a][30:0], 1'b1};
			end else begin
				rem_d[a] = trial[a];
				quo_d[a] = {quo_q[a][30:0], 1'b0};
			end
			// truncation toward zero: negate the magnitude quotient, keep low bits
			key_d[a] = neg_q[a] ? (~quo_q[a][KEY_BITS-1:0] + 1'b1)
			                    : quo_q[a][KEY_BITS-1:0];
		end
	end

	assign cmd.req = req_q;
	assign cmd.pt  = pt_q;
	assign cmd.key = key_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						req_q   <= req_t'(req_type);
						pt_q    <= in_pt;
						div_q   <= (grid_step == '0) ? VS_W'(1) : grid_step;
						for (int a = 0; a < 3; a++) begin
							neg_q[a] <= in_pt[a][31];
							quo_q[a] <= in_pt[a][31] ? (~in_pt[a] + 32'd1) : in_pt[a];
							rem_q[a] <= '0;
						end
						cnt_q   <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					quo_q <= quo_d;
					rem_q <= rem_d;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!fifo_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/vmnn_dist.sv @@
// ----------------------------------------------------------------------------
// vmnn_dist
// Four stage squared distance unit: difference, magnitude, square, sum.
// ----------------------------------------------------------------------------
module vmnn_dist (
	input  logic                clk,
	input  logic                arst_n,
	input  vmnn_pkg::dist_in_t  din,
	input  vmnn_pkg::point_t    ref_pt,
	output vmnn_pkg::dist_out_t dout,
	output logic                busy
);
	import vmnn_pkg::*;

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic [ENT_AW-1:0] ent_s1, ent_s2, ent_s3, ent_s4;
	point_t            pt_s1, pt_s2, pt_s3, pt_s4;
	logic [2:0][32:0]  d_s1;
	logic [2:0][31:0]  mag_s2;
	logic [2:0][63:0]  sq_s3;
	logic [SUM_W-1:0]  sum_s4;

	assign busy      = vld_s1 || vld_s2 || vld_s3 || vld_s4;
	assign dout.vld  = vld_s4;
	assign dout.ent  = ent_s4;
	assign dout.pt   = pt_s4;
	assign dout.sum  = sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= din.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1 <= din.ent;
		pt_s1  <= din.pt;
		ent_s2 <= ent_s1;
		pt_s2  <= pt_s1;
		ent_s3 <= ent_s2;
		pt_s3  <= pt_s2;
		ent_s4 <= ent_s3;
		pt_s4  <= pt_s3;
		for (int a = 0; a < 3; a++) begin
			d_s1[a]   <= {din.pt[a][31], din.pt[a]} - {ref_pt[a][31], ref_pt[a]};
			// a difference of two 32 bit values has a magnitude below 2^32
			mag_s2[a] <= d_s1[a][32] ? 32'(~d_s1[a] + 33'd1) : d_s1[a][31:0];
			sq_s3[a]  <= 64'(mag_s2[a]) * 64'(mag_s2[a]);
		end
		sum_s4 <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
	end

endmodule

@@ hw/rtl/vmnn_back.sv @@
// ----------------------------------------------------------------------------
// vmnn_back
// Table engine: clears the entry table after reset, then carries out queued
// add, prune and query commands by sweeping the entry table once per command.
// ----------------------------------------------------------------------------
module vmnn_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fifo_empty,
	input  vmnn_pkg::cmd_t              cmd_in,
	output logic                        pop,
	input  logic [vmnn_pkg::MD2_W-1:0]  md2,
	input  logic [vmnn_pkg::CNT_W-1:0]  lim,
	output logic                        clearing,
	output logic                        done,
	output vmnn_pkg::res_t              res
);
	import vmnn_pkg::*;

	typedef enum logic [2:0] {
		B_CLR,
		B_IDLE,
		B_ADD,
		B_PRN,
		B_QSCAN,
		B_QPTS
	} bstate_t;

	localparam logic [1:0] OFF_NEG  = 2'd0;
	localparam logic [1:0] OFF_ZERO = 2'd1;
	localparam logic [1:0] OFF_POS  = 2'd2;
	localparam logic [1:0] OFF_NONE = 2'd3;

	bstate_t             state_q;
	logic [ENT_AW-1:0]   clr_q;
	logic [SCAN_W-1:0]   scan_q;
	logic                chk_s1;
	logic [ENT_AW-1:0]   idx_s1;
	logic                pis_s1;
	cmd_t                cmd_q;
	logic                done_q;
	res_t                res_q;

	logic                hit_q;
	logic [ENT_AW-1:0]   hit_ent_q;
	logic [CNT_W-1:0]    hit_cnt_q;
	logic                free_q;
	logic [ENT_AW-1:0]   free_ent_q;
	logic [SCAN_W-1:0]   removed_q;

	logic [NEIGHBOR_SPAN-1:0] nb_hit_q;
	logic [ENT_AW-1:0]   nb_ent_q [NEIGHBOR_SPAN];
	logic [CNT_W-1:0]    nb_cnt_q [NEIGHBOR_SPAN];
	logic [NB_W-1:0]     v_q;
	logic [CNT_W-1:0]    t_q;
	logic                found_q;
	logic [SUM_W-1:0]    best_q;
	point_t              best_pt_q;

	logic                ent_we;
	logic [ENT_AW-1:0]   ent_waddr;
	entry_t              ent_wdata;
	logic [ENT_AW-1:0]   ent_raddr;
	entry_t              ent_rdata;
	logic                pt_we;
	logic [PT_AW-1:0]    pt_waddr;
	point_t              pt_wdata;
	logic [PT_AW-1:0]    pt_raddr;
	point_t              pt_rdata;

	dist_in_t            din;
	dist_out_t           dout;
	logic                dist_busy;

	logic                scanning;
	logic                scan_live;
	logic                scan_end;
	logic [2:0][1:0]     off;
	logic [KEY_BITS-1:0] dk [3];
	logic                nb_match;
	logic [NB_W-1:0]     nb_v;
	logic [NB_W-1:0]     vi;
	logic                v_live;
	logic                prune_hit;
	logic                pt_take;
	logic                fin;
	res_t                fin_res;

	assign clearing  = (state_q == B_CLR);
	assign done      = done_q;
	assign res       = res_q;
	assign pop       = (state_q == B_IDLE) && !fifo_empty;
	assign scanning  = (state_q == B_ADD) || (state_q == B_PRN) || (state_q == B_QSCAN);
	assign scan_live = (scan_q < SCAN_W'(MAP_CAPACITY));
	assign scan_end  = !scan_live && !chk_s1;
	assign v_live    = (v_q < NB_W'(NEIGHBOR_SPAN));
	assign vi        = v_live ? v_q : '0;
	assign prune_hit = dout.vld && (dout.sum > SUM_W'(md2));
	assign pt_take   = (state_q == B_QPTS) && v_live && nb_hit_q[vi] && (t_q < nb_cnt_q[vi]);

	// offset of the entry's voxel from the query voxel, per axis, with wrap
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dk[a] = ent_rdata.key[a] - cmd_q.key[a];
			if (dk[a] == {KEY_BITS{1'b1}}) begin
				off[a] = OFF_NEG;
			end else if (dk[a] == '0) begin
				off[a] = OFF_ZERO;
			end else if (dk[a] == KEY_BITS'(1)) begin
				off[a] = OFF_POS;
			end else begin
				off[a] = OFF_NONE;
			end
		end
		nb_match = (off[0] != OFF_NONE) && (off[1] != OFF_NONE) && (off[2] != OFF_NONE);
		nb_v     = NB_W'(off[0]) * NB_W'(9) + NB_W'(off[1]) * NB_W'(3) + NB_W'(off[2]);
	end

	// end of a command and its result
	always_comb begin
		fin     = 1'b0;
		fin_res = '0;
		case (state_q)
			B_IDLE: begin
				fin = !fifo_empty && (cmd_in.req == REQ_NONE);
			end
			B_ADD: begin
				if (scan_end) begin
					fin            = 1'b1;
					fin_res.status = (!hit_q && !free_q) ? ST_FULL : ST_OK;
				end
			end
			B_PRN: begin
				if (scan_end && !dist_busy) begin
					fin             = 1'b1;
					fin_res.removed = RCNT_W'(removed_q);
				end
			end
			B_QPTS: begin
				if (!v_live && !pis_s1 && !dist_busy) begin
					fin            = 1'b1;
					fin_res.status = found_q ? ST_OK : ST_NONE;
					fin_res.near   = found_q ? best_pt_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ent_raddr = scan_q[ENT_AW-1:0];
		pt_raddr  = {scan_q[ENT_AW-1:0], PT_IW'(0)};
		if (state_q == B_QPTS) begin
			pt_raddr = {nb_ent_q[vi], t_q[PT_IW-1:0]};
		end
		ent_we    = 1'b0;
		ent_waddr = clr_q;
		ent_wdata = '0;
		pt_we     = 1'b0;
		pt_waddr  = {hit_ent_q, hit_cnt_q[PT_IW-1:0]};
		pt_wdata  = cmd_q.pt;
		case (state_q)
			B_CLR: begin
				ent_we = 1'b1;
			end
			B_ADD: begin
				if (scan_end) begin
					if (hit_q) begin
						if (hit_cnt_q < lim) begin
							pt_we           = 1'b1;
							ent_we          = 1'b1;
							ent_waddr       = hit_ent_q;
							ent_wdata.valid = 1'b1;
							ent_wdata.count = hit_cnt_q + 1'b1;
							ent_wdata.key   = cmd_q.key;
						end
					end else if (free_q) begin
						ent_we          = 1'b1;
						ent_waddr       = free_ent_q;
						ent_wdata.valid = 1'b1;
						ent_wdata.count = CNT_W'(1);
						ent_wdata.key   = cmd_q.key;
						pt_we           = 1'b1;
						pt_waddr        = {free_ent_q, PT_IW'(0)};
					end
				end
			end
			B_PRN: begin
				if (prune_hit) begin
					ent_we    = 1'b1;
					ent_waddr = dout.ent;
				end
			end
			default: begin
			end
		endcase
	end

	assign din.vld = ((state_q == B_PRN) && chk_s1 && ent_rdata.valid) ||
	                 ((state_q == B_QPTS) && pis_s1);
	assign din.ent = idx_s1;
	assign din.pt  = pt_rdata;

	vmnn_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAP_CAPACITY)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	vmnn_ram #(
		.WIDTH($bits(point_t)),
		.DEPTH(PT_DEPTH)
	) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	vmnn_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.ref_pt (cmd_q.pt),
		.dout   (dout),
		.busy   (dist_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLR;
			clr_q    <= '0;
			scan_q   <= '0;
			chk_s1   <= 1'b0;
			pis_s1   <= 1'b0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			found_q  <= 1'b0;
			nb_hit_q <= '0;
			v_q      <= '0;
			t_q      <= '0;
		end else begin
			done_q <= fin;
			if (fin) begin
				res_q <= fin_res;
			end
			chk_s1 <= scanning && scan_live;
			pis_s1 <= pt_take;
			if (scanning && scan_live) begin
				idx_s1 <= scan_q[ENT_AW-1:0];
				scan_q <= scan_q + 1'b1;
			end
			case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ENT_AW'(MAP_CAPACITY - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (!fifo_empty) begin
						cmd_q     <= cmd_in;
						scan_q    <= '0;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						removed_q <= '0;
						found_q   <= 1'b0;
						nb_hit_q  <= '0;
						v_q       <= '0;
						t_q       <= '0;
						case (cmd_in.req)
							REQ_ADD:   state_q <= B_ADD;
							REQ_PRUNE: state_q <= B_PRN;
							REQ_QUERY: state_q <= B_QSCAN;
							default: begin
							end
						endcase
					end
				end
				B_ADD: begin
					if (chk_s1) begin
						if (ent_rdata.valid && (ent_rdata.key == cmd_q.key)) begin
							hit_q     <= 1'b1;
							hit_ent_q <= idx_s1;
							hit_cnt_q <= ent_rdata.count;
						end
						if (!ent_rdata.valid && !free_q) begin
							free_q     <= 1'b1;
							free_ent_q <= idx_s1;
						end
					end
					if (fin) begin
						state_q <= B_IDLE;
					end
				end
				B_PRN: begin
					if (prune_hit) begin
						removed_q <= removed_q + 1'b1;
					end
					if (fin) begin
						state_q <= B_IDLE;
					end
				end
				B_QSCAN: begin
					if (chk_s1 && ent_rdata.valid && nb_match) begin
						nb_hit_q[nb_v] <= 1'b1;
						nb_ent_q[nb_v] <= idx_s1;
						nb_cnt_q[nb_v] <= (ent_rdata.count > CNT_W'(MAX_POINTS)) ?
						                  CNT_W'(MAX_POINTS) : ent_rdata.count;
					end
					if (scan_end) begin
						state_q <= B_QPTS;
					end
				end
				B_QPTS: begin
					// points leave in neighbour then insertion order, so a strict
					// compare keeps the first of equal distances
					if (v_live) begin
						if (pt_take) begin
							t_q <= t_q + 1'b1;
						end else begin
							v_q <= v_q + 1'b1;
							t_q <= '0;
						end
					end
					if (dout.vld && (!found_q || (dout.sum < best_q))) begin
						found_q   <= 1'b1;
						best_q    <= dout.sum;
						best_pt_q <= dout.pt;
					end
					if (fin) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/voxel_map_nearest_neighbor.sv @@
// ----------------------------------------------------------------------------
// voxel_map_nearest_neighbor
// Voxel keyed point map with point add, prune around an origin and nearest
// neighbour query over the surrounding 3x3x3 voxels.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// for a single cycle with done high and cannot be held off. After reset the
// entry table is cleared, one entry a cycle, with busy high. The front end
// works each item through three restoring dividers, one quotient bit a
// cycle, then hands it over once the queue has room; a two deep queue lets
// it take further items while the back end works. The back end sweeps the
// whole entry table once per add, prune or query item, one entry a cycle;
// a query then visits each of the 27 neighbouring voxels and each point
// stored in them (at most 432), and drains the distance pipeline.
// Configuration is to be written by the user only while no item is in
// hand; the block itself does not enforce this.
module voxel_map_nearest_neighbor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       req_type,
	input  logic signed [31:0]               x,
	input  logic signed [31:0]               y,
	input  logic signed [31:0]               z,
	output logic                             done,
	output logic [1:0]                       status,
	output logic signed [31:0]               near_x,
	output logic signed [31:0]               near_y,
	output logic signed [31:0]               near_z,
	output logic [12:0]                      removed_count,
	input  logic                             cfg_we,
	input  logic [vmnn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vmnn_pkg::VS_W-1:0]        cfg_data
);
	import vmnn_pkg::*;

	logic [VS_W-1:0]  grid_step_q;
	logic [VS_W-1:0]  max_dist_q;
	logic [PPV_W-1:0] ppv_q;
	logic [MD2_W-1:0] md2_q;
	logic [CNT_W-1:0] lim_q;

	logic   front_busy;
	logic   clearing;
	logic   push;
	logic   pop;
	logic   fifo_full;
	logic   fifo_empty;
	cmd_t   push_cmd;
	cmd_t   pop_cmd;
	res_t   res;

	assign busy          = front_busy;
	assign status        = res.status;
	assign near_x        = res.near[0];
	assign near_y        = res.near[1];
	assign near_z        = res.near[2];
	assign removed_count = res.removed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_step_q <= VS_W'(65536);
			max_dist_q  <= VS_W'(6553600);
			ppv_q       <= PPV_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_STEP:  grid_step_q <= cfg_data;
				CFG_MAX_DIST:   max_dist_q  <= cfg_data;
				CFG_POINTS_PER: ppv_q       <= cfg_data[PPV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// squared radius and clamped point limit, settled well before any item
	always_ff @(posedge clk) begin
		md2_q <= max_dist_q * max_dist_q;
		if (ppv_q == '0) begin
			lim_q <= CNT_W'(1);
		end else if (int'(ppv_q) > MAX_POINTS) begin
			lim_q <= CNT_W'(MAX_POINTS);
		end else begin
			lim_q <= CNT_W'(ppv_q);
		end
	end

	vmnn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (front_busy),
		.req_type   (req_type),
		.x          (x),
		.y          (y),
		.z          (z),
		.grid_step  (grid_step_q),
		.hold       (clearing),
		.fifo_full  (fifo_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	vmnn_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (pop_cmd),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	vmnn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.cmd_in     (pop_cmd),
		.pop        (pop),
		.md2        (md2_q),
		.lim        (lim_q),
		.clearing   (clearing),
		.done       (done),
		.res        (res)
	);

endmodule
